FILE: sv/lbvs_pkg.sv
package lbvs_pkg;

	localparam int MAX_BONES_DEF  = 256;
	localparam int INFLUENCES_DEF = 4;
	localparam int ELEMS          = 12;

	localparam logic [1:0] MODE_BLEND = 2'd0;
	localparam logic [1:0] MODE_RIGID = 2'd1;
	localparam logic [1:0] MODE_OWNER = 2'd2;

	localparam logic [1:0] REG_SKIN_MODE  = 2'd0;
	localparam logic [1:0] REG_BONE_COUNT = 2'd1;
	localparam logic [1:0] REG_OWNER_SLOT = 2'd2;

	// datapath widths
	localparam int PP_W   = 48;
	localparam int ROW_W  = 50;
	localparam int WROW_W = 59;
	localparam int SUM_W  = 61;
	localparam int X_W    = 40;
	localparam int SER_W  = 41;
	localparam int Q0_W   = 33;
	localparam int VM_W   = 30;
	localparam int SQ_W   = 64;
	localparam int LEN_W  = 31;
	localparam int NUM_W  = 45;
	localparam int QUO_W  = 15;
	localparam int SQRT_STEPS = 32;

	// stage numbering
	localparam int S_SQ0  = 11;
	localparam int S_NUM  = S_SQ0 + SQRT_STEPS;
	localparam int S_DIV0 = S_NUM + 1;
	localparam int S_OUT  = S_DIV0 + QUO_W;
	localparam int N_STG  = S_OUT;

	// 255 * 2^31 + 127: any blend magnitude above this saturates anyway
	localparam logic [X_W-1:0] BLEND_CAP = X_W'(64'd547608330367);

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [7:0]       dom;
		logic             thru;
		logic [2:0]       nneg;
	} res_side_t;

	typedef struct packed {
		res_side_t             res;
		logic [2:0][VM_W-1:0]  vm;
	} sqrt_side_t;

	typedef struct packed {
		res_side_t res;
		logic      lzero;
	} div_side_t;

endpackage

FILE: sv/lbvs_sqrt.sv
module lbvs_sqrt (
	input  logic                                 clk,
	input  logic [lbvs_pkg::SQRT_STEPS-1:0]      en,
	input  logic [lbvs_pkg::SQ_W-1:0]            x_in,
	input  lbvs_pkg::sqrt_side_t                 side_in,
	output logic [lbvs_pkg::LEN_W-1:0]           len_out,
	output lbvs_pkg::sqrt_side_t                 side_out
);
	import lbvs_pkg::*;

	logic [SQ_W-1:0] x_s    [SQRT_STEPS];
	logic [SQ_W-1:0] r_s    [SQRT_STEPS];
	sqrt_side_t      side_s [SQRT_STEPS];

	// one bit of the root per stage, bit weight b = 4^(31-j)
	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [SQ_W-1:0] B = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [SQ_W-1:0] xi, ri, t;
		sqrt_side_t      si;

		if (j == 0) begin : g_first
			assign xi = x_in;
			assign ri = '0;
			assign si = side_in;
		end else begin : g_next
			assign xi = x_s[j-1];
			assign ri = r_s[j-1];
			assign si = side_s[j-1];
		end

		assign t = ri + B;

		always_ff @(posedge clk) begin
			if (en[j]) begin
				if (xi >= t) begin
					x_s[j] <= xi - t;
					r_s[j] <= (ri >> 1) + B;
				end else begin
					x_s[j] <= xi;
					r_s[j] <= ri >> 1;
				end
				side_s[j] <= si;
			end
		end
	end

	assign len_out  = r_s[SQRT_STEPS-1][LEN_W-1:0];
	assign side_out = side_s[SQRT_STEPS-1];

endmodule

FILE: sv/lbvs_div.sv
module lbvs_div (
	input  logic                                     clk,
	input  logic [lbvs_pkg::QUO_W-1:0]               en,
	input  logic [2:0][lbvs_pkg::NUM_W-1:0]          num_in,
	input  logic [lbvs_pkg::LEN_W-1:0]               len_in,
	input  lbvs_pkg::div_side_t                      side_in,
	output logic [2:0][lbvs_pkg::QUO_W-1:0]          quo_out,
	output lbvs_pkg::div_side_t                      side_out
);
	import lbvs_pkg::*;

	logic [2:0][NUM_W-1:0] rem_s  [QUO_W];
	logic [2:0][QUO_W-1:0] q_s    [QUO_W];
	logic [LEN_W-1:0]      len_s  [QUO_W];
	div_side_t             side_s [QUO_W];

	// restoring division, one quotient bit per stage, MSB first
	for (genvar j = 0; j < QUO_W; j++) begin : g_step
		logic [2:0][NUM_W-1:0] ri;
		logic [2:0][QUO_W-1:0] qi;
		logic [LEN_W-1:0]      li;
		div_side_t             si;
		logic [NUM_W:0]        d;

		if (j == 0) begin : g_first
			assign ri = num_in;
			assign qi = '0;
			assign li = len_in;
			assign si = side_in;
		end else begin : g_next
			assign ri = rem_s[j-1];
			assign qi = q_s[j-1];
			assign li = len_s[j-1];
			assign si = side_s[j-1];
		end

		assign d = (NUM_W + 1)'(li) << (QUO_W - 1 - j);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				for (int i = 0; i < 3; i++) begin
					if ((NUM_W + 1)'(ri[i]) >= d) begin
						rem_s[j][i] <= NUM_W'((NUM_W + 1)'(ri[i]) - d);
						q_s[j][i]   <= {qi[i][QUO_W-2:0], 1'b1};
					end else begin
						rem_s[j][i] <= ri[i];
						q_s[j][i]   <= {qi[i][QUO_W-2:0], 1'b0};
					end
				end
				len_s[j]  <= li;
				side_s[j] <= si;
			end
		end
	end

	assign quo_out  = q_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

endmodule

FILE: sv/linear_blend_vertex_skinning.sv
// Channel   Handshake                     Payload
// cfg       psel/penable/pwrite, pready   paddr, pwdata, prdata
// in        in_valid / in_ready           func, pos_*, nrm_*, bone_*, load_*
// out       out_valid / out_ready         out_x/y/z, out_nx/ny/nz, dominant_slot,
//                                         passed_through
//
// One transaction per cycle sustained while out_ready is held; a vertex result is registered
// after 59 register stages from acceptance: ten arithmetic, a 32-stage root, a numerator stage,
// a 15-stage divider, output.
// Palette loads are written at acceptance and produce no output transaction.
// Each valid stage holds while its successor holds, so bubbles close up under stall.
// arst_n clears valid bits and configuration registers; the palette is not cleared.
module linear_blend_vertex_skinning #(
	parameter int MAX_BONES  = lbvs_pkg::MAX_BONES_DEF,
	parameter int INFLUENCES = lbvs_pkg::INFLUENCES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] nrm_x,
	input  logic signed [15:0] nrm_y,
	input  logic signed [15:0] nrm_z,
	input  logic [31:0]        bone_indices,
	input  logic [31:0]        bone_weights,
	input  logic [7:0]         load_slot,
	input  logic [3:0]         load_element,
	input  logic signed [31:0] load_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [15:0] out_nx,
	output logic signed [15:0] out_ny,
	output logic signed [15:0] out_nz,
	output logic [7:0]         dominant_slot,
	output logic               passed_through
);
	import lbvs_pkg::*;

	localparam int SLOT_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

	function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-32:0] hi;
		hi = v[SUM_W-1:31];
		if (&hi || ~|hi)
			return v[31:0];
		return v[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	// ---------------- configuration ----------------
	logic [1:0] skin_mode_q;
	logic [8:0] bone_count_q;
	logic [7:0] owner_slot_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_mode_q  <= '0;
			bone_count_q <= '0;
			owner_slot_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SKIN_MODE:  skin_mode_q  <= pwdata[1:0];
				REG_BONE_COUNT: bone_count_q <= pwdata[8:0];
				REG_OWNER_SLOT: owner_slot_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SKIN_MODE:  prdata = {30'd0, skin_mode_q};
			REG_BONE_COUNT: prdata = {23'd0, bone_count_q};
			REG_OWNER_SLOT: prdata = {24'd0, owner_slot_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic [N_STG:1] v_q;
	logic [N_STG:1] en;

	always_comb begin
		en[N_STG] = !v_q[N_STG] || out_ready;
		for (int k = N_STG - 1; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1])
				v_q[1] <= in_valid && func;
			for (int k = 2; k <= N_STG; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	// ---------------- influence select ----------------
	logic [8:0] valid_cnt;
	logic [7:0] rd_slot [INFLUENCES];
	logic       take    [INFLUENCES];
	logic [7:0] weff    [INFLUENCES];
	logic       any_take;
	logic [7:0] dom_in, best_w;

	always_comb begin
		valid_cnt = (bone_count_q < 9'(MAX_BONES)) ? bone_count_q : 9'(MAX_BONES);
		for (int l = 0; l < INFLUENCES; l++) begin
			rd_slot[l] = bone_indices[8*l +: 8];
			take[l]    = 1'b0;
			weff[l]    = '0;
			case (skin_mode_q)
				MODE_BLEND: begin
					take[l] = (bone_weights[8*l +: 8] != 8'd0) && ({1'b0, rd_slot[l]} < valid_cnt);
					weff[l] = bone_weights[8*l +: 8];
				end
				MODE_RIGID: begin
					if (l == 0) begin
						take[l] = {1'b0, rd_slot[l]} < valid_cnt;
						weff[l] = 8'd1;
					end
				end
				default: begin
					if (l == 0) begin
						rd_slot[l] = owner_slot_q;
						take[l]    = {1'b0, owner_slot_q} < 9'(MAX_BONES);
						weff[l]    = 8'd1;
					end
				end
			endcase
			if (!take[l])
				weff[l] = '0;
		end
		any_take = 1'b0;
		for (int l = 0; l < INFLUENCES; l++)
			any_take = any_take | take[l];

		best_w = bone_weights[7:0];
		dom_in = bone_indices[7:0];
		for (int l = 1; l < INFLUENCES; l++) begin
			if (bone_weights[8*l +: 8] > best_w) begin
				best_w = bone_weights[8*l +: 8];
				dom_in = bone_indices[8*l +: 8];
			end
		end
		if (skin_mode_q == MODE_RIGID)
			dom_in = bone_indices[7:0];
	end

	// ---------------- stage 1: palette read, input capture ----------------
	logic wr_en;
	assign wr_en = in_valid && in_ready && !func && (load_element < 4'(ELEMS)) &&
		({1'b0, load_slot} < 9'(MAX_BONES));

	logic signed [31:0] m_s1 [INFLUENCES][ELEMS];

	for (genvar l = 0; l < INFLUENCES; l++) begin : g_lane
		for (genvar e = 0; e < ELEMS; e++) begin : g_elem
			logic [31:0] mem [MAX_BONES];
			always_ff @(posedge clk) begin
				if (wr_en && load_element == 4'(e))
					mem[load_slot[SLOT_W-1:0]] <= load_value;
				if (en[1])
					m_s1[l][e] <= mem[rd_slot[l][SLOT_W-1:0]];
			end
		end
	end

	logic signed [31:0] p_s1 [3];
	logic signed [15:0] n_s1 [3];
	logic [7:0]         w_s1 [INFLUENCES];
	logic               take_s1 [INFLUENCES];
	logic               single_s1, thru_s1;
	logic [7:0]         dom_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s1[0] <= pos_x;
			p_s1[1] <= pos_y;
			p_s1[2] <= pos_z;
			n_s1[0] <= nrm_x;
			n_s1[1] <= nrm_y;
			n_s1[2] <= nrm_z;
			for (int l = 0; l < INFLUENCES; l++) begin
				w_s1[l]    <= weff[l];
				take_s1[l] <= take[l];
			end
			single_s1 <= skin_mode_q != MODE_BLEND;
			thru_s1   <= !any_take;
			dom_s1    <= dom_in;
		end
	end

	// ---------------- stage 2: products ----------------
	logic signed [31:0] m_msk [INFLUENCES][ELEMS];
	logic signed [63:0] pprod [INFLUENCES][3][3];
	logic signed [47:0] dprod [INFLUENCES][3][3];

	always_comb begin
		for (int l = 0; l < INFLUENCES; l++)
			for (int e = 0; e < ELEMS; e++)
				m_msk[l][e] = take_s1[l] ? m_s1[l][e] : 32'sd0;
		for (int l = 0; l < INFLUENCES; l++)
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					pprod[l][r][c] = m_msk[l][4*r+c] * p_s1[c];
					dprod[l][r][c] = m_msk[l][4*r+c] * n_s1[c];
				end
	end

	logic signed [PP_W-1:0] pp_s2 [INFLUENCES][3][3];
	logic signed [PP_W-1:0] dp_s2 [INFLUENCES][3][3];
	logic signed [31:0]     t3_s2 [INFLUENCES][3];
	logic signed [31:0]     p_s2  [3];
	logic signed [15:0]     n_s2  [3];
	logic [7:0]             w_s2  [INFLUENCES];
	logic                   single_s2, thru_s2;
	logic [7:0]             dom_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int l = 0; l < INFLUENCES; l++) begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						pp_s2[l][r][c] <= pprod[l][r][c][63:16];
						dp_s2[l][r][c] <= dprod[l][r][c];
					end
					t3_s2[l][r] <= m_msk[l][4*r+3];
				end
				w_s2[l] <= w_s1[l];
			end
			p_s2      <= p_s1;
			n_s2      <= n_s1;
			single_s2 <= single_s1;
			thru_s2   <= thru_s1;
			dom_s2    <= dom_s1;
		end
	end

	// ---------------- stage 3: row sums ----------------
	logic signed [ROW_W-1:0] row_s3 [INFLUENCES][3];
	logic signed [ROW_W-1:0] dir_s3 [INFLUENCES][3];
	logic signed [31:0]      p_s3   [3];
	logic signed [15:0]      n_s3   [3];
	logic [7:0]              w_s3   [INFLUENCES];
	logic                    single_s3, thru_s3;
	logic [7:0]              dom_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < INFLUENCES; l++) begin
				for (int r = 0; r < 3; r++) begin
					row_s3[l][r] <= ROW_W'(t3_s2[l][r]) + ROW_W'(pp_s2[l][r][0]) +
						ROW_W'(pp_s2[l][r][1]) + ROW_W'(pp_s2[l][r][2]);
					dir_s3[l][r] <= ROW_W'(dp_s2[l][r][0]) + ROW_W'(dp_s2[l][r][1]) +
						ROW_W'(dp_s2[l][r][2]);
				end
				w_s3[l] <= w_s2[l];
			end
			p_s3      <= p_s2;
			n_s3      <= n_s2;
			single_s3 <= single_s2;
			thru_s3   <= thru_s2;
			dom_s3    <= dom_s2;
		end
	end

	// ---------------- stage 4: weighting ----------------
	logic signed [WROW_W-1:0] prow [INFLUENCES][3];
	logic signed [WROW_W-1:0] drow [INFLUENCES][3];

	always_comb begin
		for (int l = 0; l < INFLUENCES; l++)
			for (int r = 0; r < 3; r++) begin
				prow[l][r] = row_s3[l][r] * $signed({1'b0, w_s3[l]});
				drow[l][r] = dir_s3[l][r] * $signed({1'b0, w_s3[l]});
			end
	end

	logic signed [WROW_W-1:0] prow_s4 [INFLUENCES][3];
	logic signed [WROW_W-1:0] drow_s4 [INFLUENCES][3];
	logic signed [31:0]       p_s4    [3];
	logic signed [15:0]       n_s4    [3];
	logic                     single_s4, thru_s4;
	logic [7:0]               dom_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			prow_s4   <= prow;
			drow_s4   <= drow;
			p_s4      <= p_s3;
			n_s4      <= n_s3;
			single_s4 <= single_s3;
			thru_s4   <= thru_s3;
			dom_s4    <= dom_s3;
		end
	end

	// ---------------- stage 5: influence sum / pass-through ----------------
	logic signed [SUM_W-1:0] psum [3];
	logic signed [SUM_W-1:0] nsum [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			psum[r] = '0;
			nsum[r] = '0;
			for (int l = 0; l < INFLUENCES; l++) begin
				psum[r] = psum[r] + SUM_W'(prow_s4[l][r]);
				nsum[r] = nsum[r] + SUM_W'(drow_s4[l][r]);
			end
			if (thru_s4) begin
				psum[r] = SUM_W'(p_s4[r]);
				nsum[r] = SUM_W'(n_s4[r]);
			end
		end
	end

	logic signed [SUM_W-1:0] psum_s5 [3];
	logic signed [SUM_W-1:0] nsum_s5 [3];
	logic                    single_s5, thru_s5;
	logic [7:0]              dom_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			psum_s5   <= psum;
			nsum_s5   <= nsum;
			single_s5 <= single_s4 || thru_s4;
			thru_s5   <= thru_s4;
			dom_s5    <= dom_s4;
		end
	end

	// ---------------- stage 6: magnitudes ----------------
	logic [SUM_W-1:0] pmag [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			pmag[r] = psum_s5[r][SUM_W-1] ? SUM_W'(-psum_s5[r]) : SUM_W'(psum_s5[r]);
	end

	logic [X_W-1:0]   x_s6    [3];
	logic [2:0]       pneg_s6;
	logic [31:0]      psat_s6 [3];
	logic [SUM_W-1:0] nmag_s6 [3];
	logic [2:0]       nneg_s6;
	logic             single_s6, thru_s6;
	logic [7:0]       dom_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int r = 0; r < 3; r++) begin
				x_s6[r]    <= ((pmag[r] > SUM_W'(BLEND_CAP)) ? BLEND_CAP : pmag[r][X_W-1:0]) +
					X_W'(127);
				pneg_s6[r] <= psum_s5[r][SUM_W-1];
				psat_s6[r] <= sat32(psum_s5[r]);
				nmag_s6[r] <= nsum_s5[r][SUM_W-1] ? SUM_W'(-nsum_s5[r]) : SUM_W'(nsum_s5[r]);
				nneg_s6[r] <= nsum_s5[r][SUM_W-1];
			end
			single_s6 <= single_s5;
			thru_s6   <= thru_s5;
			dom_s6    <= dom_s5;
		end
	end

	// ---------------- stage 7: /255 series, normal leading one ----------------
	logic [SUM_W-1:0] norv;
	logic [5:0]       blen;

	always_comb begin
		norv = nmag_s6[0] | nmag_s6[1] | nmag_s6[2];
		blen = '0;
		for (int i = 0; i < SUM_W; i++)
			if (norv[i])
				blen = 6'(i + 1);
	end

	logic [SER_W-1:0] ser_s7  [3];
	logic [X_W-1:0]   x_s7    [3];
	logic [2:0]       pneg_s7;
	logic [31:0]      psat_s7 [3];
	logic [SUM_W-1:0] nmag_s7 [3];
	logic [5:0]       kshf_s7;
	logic [2:0]       nneg_s7;
	logic             single_s7, thru_s7;
	logic [7:0]       dom_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int r = 0; r < 3; r++)
				ser_s7[r] <= SER_W'(x_s6[r]) + SER_W'(x_s6[r] >> 8) + SER_W'(x_s6[r] >> 16) +
					SER_W'(x_s6[r] >> 24) + SER_W'(x_s6[r] >> 32);
			x_s7      <= x_s6;
			pneg_s7   <= pneg_s6;
			psat_s7   <= psat_s6;
			nmag_s7   <= nmag_s6;
			kshf_s7   <= (blen > 6'(VM_W)) ? blen - 6'(VM_W) : 6'd0;
			nneg_s7   <= nneg_s6;
			single_s7 <= single_s6;
			thru_s7   <= thru_s6;
			dom_s7    <= dom_s6;
		end
	end

	// ---------------- stage 8: quotient estimate, normal scale ----------------
	logic [Q0_W-1:0]  q0    [3];
	logic [X_W+1:0]   rem255 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			q0[r]     = Q0_W'(ser_s7[r] >> 8);
			rem255[r] = (X_W + 2)'(x_s7[r]) - (((X_W + 2)'(q0[r]) << 8) - (X_W + 2)'(q0[r]));
		end
	end

	logic [Q0_W-1:0] q0_s8   [3];
	logic [8:0]      r_s8    [3];
	logic [2:0]      pneg_s8;
	logic [31:0]     psat_s8 [3];
	logic [VM_W-1:0] vm_s8   [3];
	logic [2:0]      nneg_s8;
	logic            single_s8, thru_s8;
	logic [7:0]      dom_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			for (int r = 0; r < 3; r++) begin
				q0_s8[r] <= q0[r];
				r_s8[r]  <= rem255[r][8:0];
				vm_s8[r] <= VM_W'(nmag_s7[r] >> kshf_s7);
			end
			pneg_s8   <= pneg_s7;
			psat_s8   <= psat_s7;
			nneg_s8   <= nneg_s7;
			single_s8 <= single_s7;
			thru_s8   <= thru_s7;
			dom_s8    <= dom_s7;
		end
	end

	// ---------------- stage 9: final position, squares ----------------
	logic [Q0_W-1:0] qf   [3];
	logic [31:0]     posf [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			qf[r] = q0_s8[r] + Q0_W'(r_s8[r] >= 9'd255);
			if (single_s8)
				posf[r] = psat_s8[r];
			else if (pneg_s8[r])
				posf[r] = 32'(~qf[r] + Q0_W'(1));
			else if (qf[r] >= Q0_W'(33'h0_8000_0000))
				posf[r] = 32'h7FFF_FFFF;
			else
				posf[r] = qf[r][31:0];
		end
	end

	logic [31:0]       pos_s9 [3];
	logic [2*VM_W-1:0] sq_s9  [3];
	logic [VM_W-1:0]   vm_s9  [3];
	logic [2:0]        nneg_s9;
	logic              thru_s9;
	logic [7:0]        dom_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int r = 0; r < 3; r++)
				sq_s9[r] <= (2*VM_W)'(vm_s8[r]) * (2*VM_W)'(vm_s8[r]);
			pos_s9  <= posf;
			vm_s9   <= vm_s8;
			nneg_s9 <= nneg_s8;
			thru_s9 <= thru_s8;
			dom_s9  <= dom_s8;
		end
	end

	// ---------------- stage 10: sum of squares ----------------
	logic [SQ_W-1:0] ss_s10;
	sqrt_side_t      side_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			ss_s10 <= SQ_W'(sq_s9[0]) + SQ_W'(sq_s9[1]) + SQ_W'(sq_s9[2]);
			for (int r = 0; r < 3; r++) begin
				side_s10.res.pos[r] <= pos_s9[r];
				side_s10.vm[r]      <= vm_s9[r];
			end
			side_s10.res.dom  <= dom_s9;
			side_s10.res.thru <= thru_s9;
			side_s10.res.nneg <= nneg_s9;
		end
	end

	// ---------------- root ----------------
	logic [LEN_W-1:0] len_sq;
	sqrt_side_t       side_sq;

	lbvs_sqrt u_sqrt (
		.clk      (clk),
		.en       (en[S_NUM-1:S_SQ0]),
		.x_in     (ss_s10),
		.side_in  (side_s10),
		.len_out  (len_sq),
		.side_out (side_sq)
	);

	// ---------------- numerators ----------------
	logic [2:0][NUM_W-1:0] num_s43;
	logic [LEN_W-1:0]      len_s43;
	div_side_t             side_s43;

	always_ff @(posedge clk) begin
		if (en[S_NUM]) begin
			for (int r = 0; r < 3; r++)
				num_s43[r] <= (NUM_W'(side_sq.vm[r]) << 14) + NUM_W'(len_sq >> 1);
			len_s43        <= len_sq;
			side_s43.res   <= side_sq.res;
			side_s43.lzero <= len_sq == '0;
		end
	end

	// ---------------- divide ----------------
	logic [2:0][QUO_W-1:0] quo_dv;
	div_side_t             side_dv;

	lbvs_div u_div (
		.clk      (clk),
		.en       (en[S_OUT-1:S_DIV0]),
		.num_in   (num_s43),
		.len_in   (len_s43),
		.side_in  (side_s43),
		.quo_out  (quo_dv),
		.side_out (side_dv)
	);

	// ---------------- output register ----------------
	logic [15:0] nout [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (side_dv.lzero)
				nout[r] = '0;
			else if (side_dv.res.nneg[r])
				nout[r] = 16'(-{1'b0, quo_dv[r]});
			else
				nout[r] = {1'b0, quo_dv[r]};
		end
	end

	logic [31:0] pos_s59 [3];
	logic [15:0] nrm_s59 [3];
	logic [7:0]  dom_s59;
	logic        thru_s59;

	always_ff @(posedge clk) begin
		if (en[S_OUT]) begin
			for (int r = 0; r < 3; r++)
				pos_s59[r] <= side_dv.res.pos[r];
			nrm_s59  <= nout;
			dom_s59  <= side_dv.res.dom;
			thru_s59 <= side_dv.res.thru;
		end
	end

	assign out_valid      = v_q[S_OUT];
	assign out_x          = pos_s59[0];
	assign out_y          = pos_s59[1];
	assign out_z          = pos_s59[2];
	assign out_nx         = nrm_s59[0];
	assign out_ny         = nrm_s59[1];
	assign out_nz         = nrm_s59[2];
	assign dominant_slot  = dom_s59;
	assign passed_through = thru_s59;

	// ---------------- assertions ----------------
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !func) |=> !v_q[1])
		else $error("palette load entered the vertex pipeline");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_q[1] |-> in_ready)
		else $error("empty first stage refused a transaction");

	a_unit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_nx <= 16'sd16384 && out_nx >= -16'sd16384 &&
			out_ny <= 16'sd16384 && out_ny >= -16'sd16384 &&
			out_nz <= 16'sd16384 && out_nz >= -16'sd16384))
		else $error("normal component exceeds unit length");

endmodule
